// ===== rtl/spiq_pkg.sv =====
// ----------------------------------------------------------------------------
// spiq_pkg
// Shared types, codes and the pad frame builder for the scripted pad queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spiq_pkg;

	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] CFG_ID_DISCONNECTED = 2'd0;
	localparam logic [1:0] CFG_ID_ERROR        = 2'd1;
	localparam logic [1:0] CFG_ID_DIGITAL      = 2'd2;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	localparam logic STATUS_QUEUED   = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	localparam logic [7:0] BYTE_FILL   = 8'hFF;
	localparam logic [7:0] BYTE_CENTER = 8'h80;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;

	localparam logic [7:0] RST_ID_DISCONNECTED = 8'd0;
	localparam logic [7:0] RST_ID_ERROR        = 8'd255;
	localparam logic [7:0] RST_ID_DIGITAL      = 8'd65;

	typedef struct packed {
		logic [7:0] id_disconnected;
		logic [7:0] id_error;
		logic [7:0] id_digital;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  port;
		logic [15:0] button_mask;
		logic [15:0] frame_count;
		logic [7:0]  pad_id_zero;
		logic [7:0]  pad_id_one;
	} item_t;

	typedef struct packed {
		logic        reply_kind;
		logic        out_port;
		logic [63:0] pad_frame;
		logic        status;
		logic [6:0]  queue_len;
		logic [47:0] frame_number;
		logic        last;
	} res_t;

	function automatic logic [63:0] build_frame(input logic [7:0] kind,
		input logic [15:0] mask, input cfg_t cfg);
		logic [7:0] analog;
		logic [63:0] f;
		analog = (kind == cfg.id_digital) ? BYTE_ZERO : BYTE_CENTER;
		f = {analog, analog, analog, analog, ~mask[7:0], ~mask[15:8], kind, BYTE_ZERO};
		if (kind == cfg.id_disconnected || kind == cfg.id_error) begin
			f = {8{BYTE_FILL}};
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/scripted_pad_input_queue.sv =====
// ----------------------------------------------------------------------------
// scripted_pad_input_queue
// Per-port ring queues of scripted button segments, played out as pad frames.
//
// Items enter on the s_ stream: tuser carries the operation (push, tick,
// clear), tdata the port, mask, frame count and both current pad ids.
// Results leave on the m_ stream: tuser is the result kind (pad frame or push
// reply), tlast marks the final result of an item.
// A push enters, then its reply is formed. A tick enters, then skips each
// empty port and, for each busy port, does a registered read of the segment
// memory followed by the write-back of the decremented head segment. A clear
// enters, then forms one frame per served port. One item is in work at a
// time; the output register lets the next item enter while a result waits
// for m_tready. A stalled receiver holds the sequencer at its next result.
// Reset empties both queues, zeroes the frame counter and loads the default
// pad id codes; the segment memory needs no clearing.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata.
// ----------------------------------------------------------------------------
`default_nettype none

module scripted_pad_input_queue import spiq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int PORT_COUNT = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// port, button_mask, frame_count, pad_id_zero, pad_id_one
	input  wire logic [55:0]  s_tdata,
	// func
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_port, pad_frame, status, queue_len, frame_number
	output logic      [127:0] m_tdata,
	// reply_kind
	output logic      [0:0]   m_tuser,
	output logic              m_tlast,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [7:0]   cfg_wdata
);

	localparam int MEM_DEPTH = QUEUE_DEPTH * PORT_COUNT;
	localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	cfg_t           cfg_q;
	item_t          item;
	res_t           res;
	res_t           out_q;
	logic           m_tvalid_q;
	logic           res_valid;
	logic           res_ready;
	logic           mem_we;
	logic [MAW-1:0] mem_waddr;
	logic [31:0]    mem_wdata;
	logic           mem_re;
	logic [MAW-1:0] mem_raddr;
	logic [31:0]    mem_rdata;

	assign item.func = s_tuser;
	assign item.port = s_tdata[1:0];
	assign item.button_mask = s_tdata[17:2];
	assign item.frame_count = s_tdata[33:18];
	assign item.pad_id_zero = s_tdata[41:34];
	assign item.pad_id_one = s_tdata[49:42];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.id_disconnected <= RST_ID_DISCONNECTED;
			cfg_q.id_error <= RST_ID_ERROR;
			cfg_q.id_digital <= RST_ID_DIGITAL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ID_DISCONNECTED: cfg_q.id_disconnected <= cfg_wdata;
				CFG_ID_ERROR:        cfg_q.id_error <= cfg_wdata;
				CFG_ID_DIGITAL:      cfg_q.id_digital <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	spiq_engine #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PORT_COUNT(PORT_COUNT)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item(item),
		.cfg(cfg_q),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res(res),
		.res_ready(res_ready)
	);

	spiq_store #(
		.DEPTH(MEM_DEPTH),
		.DW(32)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {7'd0, out_q.frame_number, out_q.queue_len, out_q.status,
		out_q.pad_frame, out_q.out_port};
	assign m_tuser = out_q.reply_kind;
	assign m_tlast = out_q.last;

endmodule

`default_nettype wire

// ===== rtl/spiq_store.sv =====
// ----------------------------------------------------------------------------
// spiq_store
// Segment memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spiq_store #(
	parameter int DEPTH = 128,
	parameter int DW = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spiq_engine.sv =====
// ----------------------------------------------------------------------------
// spiq_engine
// Queue sequencer: holds heads, counts and the frame counter, and walks each
// tick through read, modify and write-back of the segment memory.
// ----------------------------------------------------------------------------
`default_nettype none

module spiq_engine import spiq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int PORT_COUNT = 2,
	localparam int MEM_DEPTH = QUEUE_DEPTH * PORT_COUNT,
	localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire item_t          in_item,
	input  wire cfg_t           cfg,
	output logic                mem_we,
	output logic      [MAW-1:0] mem_waddr,
	output logic      [31:0]    mem_wdata,
	output logic                mem_re,
	output logic      [MAW-1:0] mem_raddr,
	input  wire logic [31:0]    mem_rdata,
	output logic                res_valid,
	output res_t                res,
	input  wire logic           res_ready
);

	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int SERVED = (PORT_COUNT < 2) ? PORT_COUNT : 2;
	localparam logic LAST_CUR = 1'(SERVED - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_READ,
		S_MOD,
		S_CLEAR
	} state_t;

	state_t        state_q;
	item_t         item_q;
	logic          cur_q;
	logic [HW-1:0] head_q [PORT_COUNT];
	logic [CW-1:0] count_q [PORT_COUNT];
	logic [47:0]   tick_q;

	logic [PW-1:0] p_idx;
	logic          port_ok;
	logic [CW-1:0] p_count;
	logic          push_ok;
	logic [HW:0]   tail_sum;
	logic [HW-1:0] tail_idx;
	logic [CW-1:0] push_queued;

	logic [PW-1:0] c_idx;
	logic [7:0]    c_id;
	logic [15:0]   left;
	logic          pop;
	logic          later_busy;
	logic          fire;

	assign p_idx = PW'(item_q.port);
	assign port_ok = ({30'd0, item_q.port} < 32'(SERVED));
	assign p_count = count_q[p_idx];
	assign push_ok = port_ok && (item_q.frame_count != 16'd0) &&
		(p_count < CW'(QUEUE_DEPTH));
	assign tail_sum = (HW+1)'(head_q[p_idx]) + (HW+1)'(HW'(p_count));
	assign tail_idx = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ?
		HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
	assign push_queued = !port_ok ? '0 : (push_ok ? p_count + CW'(1) : p_count);

	assign c_idx = PW'(cur_q);
	assign c_id = cur_q ? item_q.pad_id_one : item_q.pad_id_zero;
	assign left = (mem_rdata[31:16] != 16'd0) ? mem_rdata[31:16] - 16'd1 : 16'd0;
	assign pop = (left == 16'd0);
	assign later_busy = (SERVED > 1) ? (count_q[PW'(SERVED - 1)] != '0) : 1'b0;
	assign fire = res_valid && res_ready;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		res_valid = 1'b0;
		res = '0;
		res.frame_number = tick_q;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = MAW'(MAW'(c_idx) * MAW'(QUEUE_DEPTH) + MAW'(head_q[c_idx]));
		case (state_q)
			S_PUSH: begin
				res_valid = 1'b1;
				res.reply_kind = KIND_REPLY;
				res.status = push_ok ? STATUS_QUEUED : STATUS_REJECTED;
				res.queue_len = 7'(push_queued);
				res.last = 1'b1;
				mem_we = push_ok && res_ready;
				mem_waddr = MAW'(MAW'(p_idx) * MAW'(QUEUE_DEPTH) + MAW'(tail_idx));
				mem_wdata = {item_q.frame_count, item_q.button_mask};
			end
			S_READ: begin
				mem_re = (count_q[c_idx] != '0);
			end
			S_MOD: begin
				res_valid = 1'b1;
				res.reply_kind = KIND_FRAME;
				res.out_port = cur_q;
				res.pad_frame = build_frame(c_id, mem_rdata[15:0], cfg);
				res.status = STATUS_QUEUED;
				res.queue_len = 7'(pop ? count_q[c_idx] - CW'(1) : count_q[c_idx]);
				res.last = (cur_q == LAST_CUR) || !later_busy;
				mem_we = res_ready;
				mem_waddr = mem_raddr;
				mem_wdata = {left, mem_rdata[15:0]};
			end
			S_CLEAR: begin
				res_valid = 1'b1;
				res.reply_kind = KIND_FRAME;
				res.out_port = cur_q;
				res.pad_frame = build_frame(c_id, 16'h0000, cfg);
				res.status = STATUS_QUEUED;
				res.last = (cur_q == LAST_CUR);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= 1'b0;
			tick_q <= '0;
			for (int i = 0; i < PORT_COUNT; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					cur_q <= 1'b0;
					if (in_valid) begin
						case (in_item.func)
							FUNC_PUSH: begin
								state_q <= S_PUSH;
							end
							FUNC_TICK: begin
								tick_q <= tick_q + 48'd1;
								state_q <= S_READ;
							end
							FUNC_CLEAR: begin
								for (int i = 0; i < PORT_COUNT; i++) begin
									head_q[i] <= '0;
									count_q[i] <= '0;
								end
								state_q <= S_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				S_PUSH: begin
					if (fire) begin
						if (push_ok) begin
							count_q[p_idx] <= p_count + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (count_q[c_idx] != '0) begin
						state_q <= S_MOD;
					end else if (cur_q == LAST_CUR) begin
						state_q <= S_IDLE;
					end else begin
						cur_q <= 1'b1;
					end
				end
				S_MOD: begin
					if (fire) begin
						if (pop) begin
							head_q[c_idx] <= (head_q[c_idx] == HW'(QUEUE_DEPTH - 1)) ?
								'0 : head_q[c_idx] + HW'(1);
							count_q[c_idx] <= count_q[c_idx] - CW'(1);
						end
						if (cur_q == LAST_CUR) begin
							state_q <= S_IDLE;
						end else begin
							cur_q <= 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_CLEAR: begin
					if (fire) begin
						if (cur_q == LAST_CUR) begin
							state_q <= S_IDLE;
						end else begin
							cur_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
